@@ sv/poisson_gauss_seidel_sweep_assert.svh @@
// assertion macros for the poisson gauss-seidel sweep block
`ifndef POISSON_GAUSS_SEIDEL_SWEEP_ASSERT_SVH
`define POISSON_GAUSS_SEIDEL_SWEEP_ASSERT_SVH

// same-cycle implication
`define PGS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pgs_pkg.sv @@
// package: types, codes and saturation helper for the gauss-seidel sweep block
`default_nettype none

package pgs_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;
    localparam int Q_FRAC       = 16;
    localparam int PADDR_W      = 5;

    // item operation codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SWEEP = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ROWS     = 3'd0,
        REG_COLS     = 3'd1,
        REG_WEIGHT   = 3'd2,
        REG_INV_ROW  = 3'd3,
        REG_INV_COL  = 3'd4,
        REG_STEP_X   = 3'd5,
        REG_STEP_Y   = 3'd6,
        REG_ORIGIN_Y = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [6:0]         rows_in_use;
        logic [6:0]         cols_in_use;
        logic [30:0]        weight;
        logic [30:0]        inv_sqr_step_row;
        logic [30:0]        inv_sqr_step_col;
        logic [30:0]        step_x;
        logic signed [31:0] step_y;
        logic signed [31:0] origin_y;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } item_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRC,
        ST_RDA,
        ST_RDD,
        ST_SWCHK,
        ST_RY,
        ST_RY2,
        ST_RUP,
        ST_RDN,
        ST_RLF,
        ST_RRT,
        ST_RCT,
        ST_MV,
        ST_MH,
        ST_MX,
        ST_MS,
        ST_INN,
        ST_MW,
        ST_WB,
        ST_FIN
    } st_t;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh7FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -66'sh80000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/pgs_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none

module pgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/pgs_engine.sv @@
// sequencer and shared multiplier datapath around the grid memory
`default_nettype none

module pgs_engine
    import pgs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire item_t              item,
    input  wire cfg_t               cfg,
    input  wire logic               res_ready,
    output logic                    busy,
    output logic                    done,
    output logic signed [31:0]      res_data,
    output logic [1:0]              res_kind
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
    localparam int NW0   = ((RW > CW) ? RW : CW) + 1;
    localparam int NW    = (NW0 > 7) ? NW0 : 7;

    st_t state_reg, state_next;

    item_t              item_reg;
    logic               inside_reg;
    logic [AW-1:0]      op_addr_reg;
    logic [RW-1:0]      r_reg;
    logic [CW-1:0]      c_reg;
    logic [AW-1:0]      base_reg;
    logic signed [31:0] nb_reg;
    logic signed [32:0] sum_v_reg;
    logic signed [32:0] sum_h_reg;
    logic signed [31:0] old_reg;
    logic signed [31:0] vert_reg;
    logic signed [31:0] horz_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] inner_reg;
    logic signed [65:0] prod_reg;
    logic [30:0]        resid_reg;
    logic signed [31:0] res_reg;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [31:0]        wdata;
    logic [AW-1:0]      raddr;
    logic [31:0]        rdata;
    logic signed [31:0] rdata_s;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [AW-1:0]      cur_addr;
    logic [NW-1:0]      nr_eff;
    logic [NW-1:0]      nc_eff;
    logic               more_cols;
    logic               more_rows;
    logic signed [31:0] nv;
    logic signed [32:0] diff;
    logic [32:0]        adiff;
    logic [30:0]        change;

    pgs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // grid extent clamped to the store
    assign nr_eff = (NW'(cfg.rows_in_use) > NW'(MAX_ROWS)) ? NW'(MAX_ROWS)
                                                          : NW'(cfg.rows_in_use);
    assign nc_eff = (NW'(cfg.cols_in_use) > NW'(MAX_COLS)) ? NW'(MAX_COLS)
                                                          : NW'(cfg.cols_in_use);
    assign more_cols = (NW'(c_reg) + NW'(2)) < nc_eff;
    assign more_rows = (NW'(r_reg) + NW'(2)) < nr_eff;
    assign cur_addr  = base_reg + AW'(c_reg);
    assign rdata_s   = $signed(rdata);

    // new cell value and its change
    assign nv     = sat32(prod_reg >>> Q_FRAC);
    assign diff   = 33'(nv) - 33'(old_reg);
    assign adiff  = diff[32] ? 33'(-diff) : 33'(diff);
    assign change = (adiff > 33'h7FFFFFFF) ? 31'h7FFFFFFF : adiff[30:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (item.op)
                        OP_WRITE: state_next = ST_WRC;
                        OP_SWEEP: state_next = ST_SWCHK;
                        OP_READ:  state_next = ST_RDA;
                        default:  state_next = ST_FIN;
                    endcase
                end
            end
            ST_WRC:   state_next = ST_FIN;
            ST_RDA:   state_next = ST_RDD;
            ST_RDD:   state_next = ST_FIN;
            ST_SWCHK:
            begin
                if (nr_eff < NW'(3) || nc_eff < NW'(3))
                    state_next = ST_FIN;
                else
                    state_next = ST_RY;
            end
            ST_RY:    state_next = ST_RY2;
            ST_RY2:   state_next = ST_RUP;
            ST_RUP:   state_next = ST_RDN;
            ST_RDN:   state_next = ST_RLF;
            ST_RLF:   state_next = ST_RRT;
            ST_RRT:   state_next = ST_RCT;
            ST_RCT:   state_next = ST_MV;
            ST_MV:    state_next = ST_MH;
            ST_MH:    state_next = ST_MX;
            ST_MX:    state_next = ST_MS;
            ST_MS:    state_next = ST_INN;
            ST_INN:   state_next = ST_MW;
            ST_MW:    state_next = ST_WB;
            ST_WB:
            begin
                if (more_cols)
                    state_next = ST_RUP;
                else if (more_rows)
                    state_next = ST_RY;
                else
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // memory ports, multiplier operands and handshake outputs
    always_comb
    begin
        we    = 1'b0;
        waddr = cur_addr;
        wdata = nv;
        raddr = cur_addr;
        mul_a = '0;
        mul_b = '0;
        busy  = (state_reg != ST_IDLE);
        done  = (state_reg == ST_FIN) && res_ready;
        case (state_reg)
            ST_WRC:
            begin
                we    = inside_reg;
                waddr = op_addr_reg;
                wdata = item_reg.value;
            end
            ST_RDA: raddr = op_addr_reg;
            ST_RY:
            begin
                mul_a = $signed({{(33-RW){1'b0}}, r_reg});
                mul_b = 33'(cfg.step_y);
            end
            ST_RUP: raddr = cur_addr - AW'(MAX_COLS);
            ST_RDN: raddr = cur_addr + AW'(MAX_COLS);
            ST_RLF: raddr = cur_addr - AW'(1);
            ST_RRT: raddr = cur_addr + AW'(1);
            ST_RCT: raddr = cur_addr;
            ST_MV:
            begin
                mul_a = sum_v_reg;
                mul_b = $signed({2'b00, cfg.inv_sqr_step_row});
            end
            ST_MH:
            begin
                mul_a = sum_h_reg;
                mul_b = $signed({2'b00, cfg.inv_sqr_step_col});
            end
            ST_MX:
            begin
                mul_a = $signed({{(33-CW){1'b0}}, c_reg});
                mul_b = $signed({2'b00, cfg.step_x});
            end
            ST_MS:
            begin
                mul_a = 33'(sat32(prod_reg));
                mul_b = 33'(y_reg);
            end
            ST_MW:
            begin
                mul_a = $signed({2'b00, cfg.weight});
                mul_b = 33'(inner_reg);
            end
            ST_WB: we = 1'b1;
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                item_reg    <= item;
                inside_reg  <= (32'(item.row) < 32'(MAX_ROWS)) &&
                               (32'(item.col) < 32'(MAX_COLS));
                op_addr_reg <= AW'(32'(item.row) * MAX_COLS + 32'(item.col));
                res_reg     <= '0;
            end
            ST_RDD: res_reg <= inside_reg ? rdata_s : 32'sd0;
            ST_SWCHK:
            begin
                r_reg     <= RW'(1);
                c_reg     <= CW'(1);
                base_reg  <= AW'(MAX_COLS);
                resid_reg <= '0;
                res_reg   <= '0;
            end
            ST_RY2:
                y_reg <= sat32(66'(cfg.origin_y) + 66'(sat32(prod_reg)));
            ST_RDN: nb_reg    <= rdata_s;
            ST_RLF: sum_v_reg <= 33'(nb_reg) + 33'(rdata_s);
            ST_RRT: nb_reg    <= rdata_s;
            ST_RCT: sum_h_reg <= 33'(nb_reg) + 33'(rdata_s);
            ST_MV:  old_reg   <= rdata_s;
            ST_MH:  vert_reg  <= sat32(prod_reg >>> Q_FRAC);
            ST_MX:  horz_reg  <= sat32(prod_reg >>> Q_FRAC);
            ST_INN:
                inner_reg <= sat32(66'(vert_reg) + 66'(horz_reg)
                                   - 66'(sat32(prod_reg >>> Q_FRAC)));
            ST_WB:
            begin
                if (change > resid_reg)
                    resid_reg <= change;
                if (more_cols)
                begin
                    c_reg <= c_reg + CW'(1);
                end
                else if (more_rows)
                begin
                    c_reg    <= CW'(1);
                    r_reg    <= r_reg + RW'(1);
                    base_reg <= base_reg + AW'(MAX_COLS);
                end
                else
                begin
                    res_reg <= $signed({1'b0, ((change > resid_reg) ? change
                                                                   : resid_reg)});
                end
            end
            default: ;
        endcase
    end

    assign res_data = res_reg;
    assign res_kind = item_reg.op;

endmodule

`default_nettype wire

@@ sv/poisson_gauss_seidel_sweep.sv @@
// Gauss-Seidel five-point Poisson relaxation over a grid memory.
// Input channel (in_valid/in_stall): op, row, col, value. op 0 writes a cell,
// op 2 reads a cell, op 1 runs one in-place sweep over the interior cells.
// Output channel (out_valid/out_stall): data and kind, exactly one word per item.
// Configuration by an APB-style port, register i at byte address 4*i.
// One item is worked at a time; in_stall is high while an item is in flight.
// Every interior cell is worked in steps: five reads of the single read port,
// then five passes through one shared 33x33 multiplier, then the write back.
// The result sits in an output register; a stalled word holds, and the block
// then waits with the next result until the word is taken.
// Reset clears the control state and loads the register defaults; the grid
// memory is not cleared and a cell reads as garbage until written.
`default_nettype none

module poisson_gauss_seidel_sweep
    import pgs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         op,
    input  wire logic [5:0]         row,
    input  wire logic [5:0]         col,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      data,
    output logic [1:0]              kind,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t               cfg_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_data_reg;
    logic [1:0]         out_kind_reg;
    item_t              item;
    logic               busy;
    logic               eng_done;
    logic signed [31:0] eng_data;
    logic [1:0]         eng_kind;
    logic               res_ready;
    logic               start;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows_in_use      <= 7'd64;
            cfg_reg.cols_in_use      <= 7'd64;
            cfg_reg.weight           <= '0;
            cfg_reg.inv_sqr_step_row <= '0;
            cfg_reg.inv_sqr_step_col <= '0;
            cfg_reg.step_x           <= '0;
            cfg_reg.step_y           <= '0;
            cfg_reg.origin_y         <= 32'sd65536;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_ROWS:     cfg_reg.rows_in_use      <= pwdata[6:0];
                REG_COLS:     cfg_reg.cols_in_use      <= pwdata[6:0];
                REG_WEIGHT:   cfg_reg.weight           <= pwdata[30:0];
                REG_INV_ROW:  cfg_reg.inv_sqr_step_row <= pwdata[30:0];
                REG_INV_COL:  cfg_reg.inv_sqr_step_col <= pwdata[30:0];
                REG_STEP_X:   cfg_reg.step_x           <= pwdata[30:0];
                REG_STEP_Y:   cfg_reg.step_y           <= $signed(pwdata);
                REG_ORIGIN_Y: cfg_reg.origin_y         <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (idx)
            REG_ROWS:     prdata = 32'(cfg_reg.rows_in_use);
            REG_COLS:     prdata = 32'(cfg_reg.cols_in_use);
            REG_WEIGHT:   prdata = 32'(cfg_reg.weight);
            REG_INV_ROW:  prdata = 32'(cfg_reg.inv_sqr_step_row);
            REG_INV_COL:  prdata = 32'(cfg_reg.inv_sqr_step_col);
            REG_STEP_X:   prdata = 32'(cfg_reg.step_x);
            REG_STEP_Y:   prdata = cfg_reg.step_y;
            REG_ORIGIN_Y: prdata = cfg_reg.origin_y;
            default:      prdata = '0;
        endcase
    end

    // input word
    assign item.op    = op;
    assign item.row   = row;
    assign item.col   = col;
    assign item.value = value;
    assign in_stall   = busy;
    assign start      = in_valid && !busy;
    assign res_ready  = !out_valid_reg || !out_stall;

    pgs_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg       (cfg_reg),
        .res_ready (res_ready),
        .busy      (busy),
        .done      (eng_done),
        .res_data  (eng_data),
        .res_kind  (eng_kind)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (eng_done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            out_data_reg <= eng_data;
            out_kind_reg <= eng_kind;
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = out_data_reg;
    assign kind      = out_kind_reg;

`include "poisson_gauss_seidel_sweep_assert.svh"

    // checks
    `PGS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "engine idle after accept")
    `PGS_ASSERT_IMP(a_done_while_busy, clk, rst_n, eng_done, busy, "result without item")
    `PGS_ASSERT_IMP(a_no_overwrite, clk, rst_n, eng_done, !out_valid_reg || !out_stall, "pending word overwritten")
    `PGS_ASSERT_NXT(a_done_shows, clk, rst_n, eng_done, out_valid, "result not presented")

endmodule

`default_nettype wire

@@ dv/poisson_gauss_seidel_sweep_tb.sv @@
// testbench for the gauss-seidel poisson sweep block: random and directed items against a local grid model
`timescale 1ns / 100ps
`default_nettype none

module poisson_gauss_seidel_sweep_tb;
    import pgs_pkg::*;

    localparam int NROW = 64;
    localparam int NCOL = 64;
    localparam int STALL_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] data;
    logic [1:0]         kind;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    poisson_gauss_seidel_sweep dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .row(row), .col(col), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .data(data), .kind(kind),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // model state
    logic signed [31:0] grid_model [NROW*NCOL];
    bit                 written    [NROW*NCOL];
    cfg_t               cfg_model;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         kind;
    } word_t;

    word_t  pending_words[$];
    int     error_count;
    bit     idle_enable;
    int     quiet_cycles;
    bit     timed_out;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Q16.16 product, floor then clamp
    function automatic logic signed [31:0] qmul(input logic signed [65:0] a,
                                                input logic signed [65:0] b);
        logic signed [65:0] p;
        p = (a * b) >>> 16;
        return sat32(p);
    endfunction

    function automatic logic signed [31:0] run_sweep();
        int nr;
        int nc;
        logic signed [31:0] resid;
        logic signed [31:0] y;
        logic signed [31:0] x;
        logic signed [31:0] vert;
        logic signed [31:0] horz;
        logic signed [31:0] src;
        logic signed [31:0] inner;
        logic signed [31:0] nv;
        logic signed [65:0] d;
        logic signed [65:0] w;
        nr = cfg_model.rows_in_use > NROW ? NROW : cfg_model.rows_in_use;
        nc = cfg_model.cols_in_use > NCOL ? NCOL : cfg_model.cols_in_use;
        resid = 0;
        for (int r = 1; r + 1 < nr; r++)
        begin
            w = 66'(r) * 66'(cfg_model.step_y);
            y = sat32(66'(cfg_model.origin_y) + 66'(sat32(w)));
            for (int c = 1; c + 1 < nc; c++)
            begin
                x = sat32(66'(c) * $signed({35'd0, cfg_model.step_x}));
                vert = qmul(66'(grid_model[(r-1)*NCOL+c]) + 66'(grid_model[(r+1)*NCOL+c]),
                            $signed({35'd0, cfg_model.inv_sqr_step_row}));
                horz = qmul(66'(grid_model[r*NCOL+c-1]) + 66'(grid_model[r*NCOL+c+1]),
                            $signed({35'd0, cfg_model.inv_sqr_step_col}));
                src = qmul(66'(x), 66'(y));
                inner = sat32(66'(vert) + 66'(horz) - 66'(src));
                nv = qmul($signed({35'd0, cfg_model.weight}), 66'(inner));
                d = 66'(nv) - 66'(grid_model[r*NCOL+c]);
                if (d < 0) d = -d;
                if (d > 66'sh7FFFFFFF) d = 66'sh7FFFFFFF;
                if (d > 66'(resid)) resid = d[31:0];
                grid_model[r*NCOL+c] = nv;
                written[r*NCOL+c] = 1'b1;
            end
        end
        return resid;
    endfunction

    function automatic void predict_word(input op_t o, input int r, input int c,
                                         input logic signed [31:0] v);
        word_t w;
        w.kind = o;
        w.data = 0;
        case (o)
            OP_WRITE:
            begin
                grid_model[r*NCOL+c] = v;
                written[r*NCOL+c] = 1'b1;
            end
            OP_SWEEP: w.data = run_sweep();
            OP_READ:  w.data = grid_model[r*NCOL+c];
            default: ;
        endcase
        pending_words.push_back(w);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    // random sender gap
    task automatic maybe_idle();
        if (idle_enable && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(posedge clk);
    endtask

    // send one word and predict it
    task automatic send_item(input op_t o, input int r, input int c,
                             input logic signed [31:0] v);
        maybe_idle();
        in_valid <= 1'b1;
        op       <= o;
        row      <= r[5:0];
        col      <= c[5:0];
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_word(o, r, c, v);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROWS:     cfg_model.rows_in_use      = v[6:0];
            REG_COLS:     cfg_model.cols_in_use      = v[6:0];
            REG_WEIGHT:   cfg_model.weight           = v[30:0];
            REG_INV_ROW:  cfg_model.inv_sqr_step_row = v[30:0];
            REG_INV_COL:  cfg_model.inv_sqr_step_col = v[30:0];
            REG_STEP_X:   cfg_model.step_x           = v[30:0];
            REG_STEP_Y:   cfg_model.step_y           = v;
            default:      cfg_model.origin_y         = v;
        endcase
        @(posedge clk);
    endtask

    task automatic set_grid(input int nr, input int nc);
        write_reg(REG_ROWS, 32'(nr));
        write_reg(REG_COLS, 32'(nc));
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            default: return $signed($urandom());
        endcase
    endfunction

    // load every not yet loaded cell of the used window with random values
    task automatic fill_window(input int nr, input int nc);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (!written[r*NCOL+c])
                    send_item(OP_WRITE, r, c, rand_value());
    endtask

    function automatic int pick_written();
        int a;
        do a = $urandom_range(0, NROW*NCOL-1); while (!written[a]);
        return a;
    endfunction

    task automatic test_directed();
        int a;
        set_grid(4, 4);
        write_reg(REG_WEIGHT, 32'h4000);
        write_reg(REG_INV_ROW, 32'h10000);
        write_reg(REG_INV_COL, 32'h10000);
        write_reg(REG_STEP_X, 32'h8000);
        write_reg(REG_STEP_Y, 32'hFFFF8000);
        write_reg(REG_ORIGIN_Y, 32'h10000);
        fill_window(4, 4);
        // far corners of the store and extreme values
        send_item(OP_WRITE, 63, 63, 32'sh7FFFFFFF);
        send_item(OP_WRITE, 0, 63, 32'sh80000000);
        send_item(OP_READ, 63, 63, 0);
        send_item(OP_READ, 0, 63, 0);
        send_item(OP_NONE, 5, 7, 32'sh12345678);
        send_item(OP_SWEEP, 0, 0, 0);
        a = pick_written();
        send_item(OP_READ, a / NCOL, a % NCOL, 0);
        send_item(OP_READ, 1, 1, 0);
        wait_drained();
    endtask

    // extreme register settings, saturation and empty-interior sweeps
    task automatic test_extremes();
        write_reg(REG_WEIGHT, 32'h7FFFFFFF);
        write_reg(REG_INV_ROW, 32'h7FFFFFFF);
        write_reg(REG_INV_COL, 32'h7FFFFFFF);
        write_reg(REG_STEP_X, 32'h7FFFFFFF);
        write_reg(REG_STEP_Y, 32'h80000000);
        write_reg(REG_ORIGIN_Y, 32'h7FFFFFFF);
        set_grid(3, 3);
        send_item(OP_SWEEP, 0, 0, 0);
        send_item(OP_READ, 1, 1, 0);
        wait_drained();
        set_grid(2, 0);
        send_item(OP_SWEEP, 0, 0, 0);
        wait_drained();
        // oversized row count clamps, narrow grid leaves no interior
        set_grid(127, 2);
        send_item(OP_SWEEP, 0, 0, 0);
        wait_drained();
        write_reg(REG_WEIGHT, 32'h3000);
        write_reg(REG_STEP_Y, 32'h7FFFFFFF);
        write_reg(REG_ORIGIN_Y, 32'h80000000);
        set_grid(4, 4);
        send_item(OP_SWEEP, 0, 0, 0);
        send_item(OP_READ, 2, 2, 0);
        wait_drained();
    endtask

    // random phases on small grids
    task automatic test_random(input int count);
        int nr;
        int nc;
        int a;
        int u;
        for (int phase = 0; phase < 4; phase++)
        begin
            nr = $urandom_range(3, 8);
            nc = $urandom_range(3, 8);
            set_grid(nr, nc);
            write_reg(REG_WEIGHT, $urandom_range(0, 32'h8000));
            write_reg(REG_INV_ROW, $urandom_range(0, 32'h40000));
            write_reg(REG_INV_COL, $urandom_range(0, 32'h40000));
            write_reg(REG_STEP_X, $urandom_range(0, 32'h20000));
            write_reg(REG_STEP_Y, $urandom());
            write_reg(REG_ORIGIN_Y, $urandom());
            fill_window(nr, nc);
            for (int i = 0; i < count / 4; i++)
            begin
                u = $urandom_range(0, 9);
                if (u < 3)
                    send_item(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                              rand_value());
                else if (u < 5)
                    send_item(OP_SWEEP, $urandom_range(0, 63), $urandom_range(0, 63),
                              $signed($urandom()));
                else if (u < 9)
                begin
                    a = pick_written();
                    send_item(OP_READ, a / NCOL, a % NCOL, $signed($urandom()));
                end
                else
                    send_item(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                              $signed($urandom()));
                if (phase == 1 && i == 5)
                    while (pending_words.size() != 0) @(posedge clk);
            end
            wait_drained();
        end
    endtask

    // receiver stall bursts
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
                report_mismatch($sformatf("unexpected word data=%h kind=%0d", data, kind));
            else
            begin
                w = pending_words.pop_front();
                if (kind !== w.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", kind, w.kind));
                if (data !== w.data)
                    report_mismatch($sformatf("data %h, expected %h (kind %0d)",
                                              data, w.data, w.kind));
            end
        end
    end

    // watchdog on acceptance activity
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_WRITE;
        row = 0;
        col = 0;
        value = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        idle_enable = 1'b1;
        cfg_model = '0;
        cfg_model.rows_in_use = 7'd64;
        cfg_model.cols_in_use = 7'd64;
        cfg_model.origin_y = 32'sh10000;
        for (int i = 0; i < NROW*NCOL; i++)
        begin
            grid_model[i] = 0;
            written[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_extremes();
        test_random(60);
        idle_enable = 1'b0;
        test_random(24);
        wait_drained();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/pgs_pkg.sv
sv/pgs_ram.sv
sv/pgs_engine.sv
sv/poisson_gauss_seidel_sweep.sv
dv/poisson_gauss_seidel_sweep_tb.sv
